/* rtl/esd_pkg.sv */
// Package with shared widths, constants and types for the epipolar distance block.
package esd_pkg;

    localparam int CoordW = 18;
    localparam int EntryW = 21;
    localparam int RowW = 63;
    localparam int LineW = 42;
    localparam int ResW = 62;
    localparam int NumW = 124;
    localparam int DenW = 86;
    localparam int OutW = 40;
    localparam int QuoW = 41;
    localparam int AddrW = 5;
    localparam int DataW = 64;

    localparam logic [AddrW-1:0] ADDR_ROW0 = 5'd0;
    localparam logic [AddrW-1:0] ADDR_ROW1 = 5'd8;
    localparam logic [AddrW-1:0] ADDR_ROW2 = 5'd16;
    localparam logic [AddrW-1:0] ADDR_MODE = 5'd24;

    localparam logic [OutW-1:0] OUT_MAX = {OutW{1'b1}};

    typedef logic signed [EntryW-1:0] entry_t;
    typedef logic signed [CoordW-1:0] coord_t;

    typedef struct packed {
        entry_t [2:0][2:0] f;
        logic              mode;
    } esd_cfg_t;

endpackage

/* rtl/esd_if.sv */
// Valid/ready channel interface carrying one payload item.
interface esd_if #(
    parameter int W = 1
) (
    input logic clk
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/esd_cfg.sv */
// APB register file holding the fundamental matrix and the distance mode.
module esd_cfg
    import esd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    output esd_cfg_t         cfg
);
    logic [RowW-1:0] row_reg [3];
    logic            mode_reg;
    logic            wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= '0;
            row_reg[1] <= '0;
            row_reg[2] <= '0;
            mode_reg <= 1'b0;
        end
        else if (wr)
        begin
            unique case (paddr)
                ADDR_ROW0: row_reg[0] <= pwdata[RowW-1:0];
                ADDR_ROW1: row_reg[1] <= pwdata[RowW-1:0];
                ADDR_ROW2: row_reg[2] <= pwdata[RowW-1:0];
                ADDR_MODE: mode_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_ROW0: prdata = {1'b0, row_reg[0]};
            ADDR_ROW1: prdata = {1'b0, row_reg[1]};
            ADDR_ROW2: prdata = {1'b0, row_reg[2]};
            ADDR_MODE: prdata = {{(DataW-1){1'b0}}, mode_reg};
            default:   prdata = '0;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                cfg.f[i][j] = row_reg[i][EntryW*j +: EntryW];
        cfg.mode = mode_reg;
    end
endmodule

/* rtl/esd_front.sv */
// Front pipeline: epilines, residual, squared numerator and denominator.
module esd_front
    import esd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  esd_cfg_t         cfg,
    input  logic             in_valid,
    input  coord_t           xu,
    input  coord_t           xv,
    input  coord_t           yu,
    input  coord_t           yv,
    output logic             out_valid,
    output logic [NumW-1:0]  num,
    output logic [DenW-1:0]  den
);
    localparam int LHalf = LineW / 2;
    localparam int RHalf = ResW / 2;

    // Stage 1: products of F with coordinates.
    logic [2:0] v_reg;
    logic signed [LineW-1:0] pl_reg [3][3];
    logic signed [LineW-1:0] pc_reg [2][3];
    coord_t yu1_reg, yv1_reg, yu2_reg, yv2_reg;
    // Stage 2: line and column sums.
    logic signed [LineW-1:0] l_reg [3];
    logic signed [LineW-1:0] c_reg [2];
    // Stage 3: residual products and partial squares of line entries.
    logic signed [ResW-1:0] rp_reg [3];
    logic [2*LHalf-1:0] phh_reg [4];
    logic [2*LHalf-1:0] phl_reg [4];
    logic [2*LHalf-1:0] pll_reg [4];
    logic mode1_reg, mode2_reg, mode3_reg, mode4_reg;
    // Stage 4: residual and squares of line entries.
    logic signed [ResW-1:0] r_reg;
    logic [DenW-1:0] sq_reg [4];
    // Stage 5: denominator and partial squares of the residual.
    logic [DenW-1:0] den5_reg;
    logic [2*RHalf-1:0] rhh_reg;
    logic [2*RHalf-1:0] rhl_reg;
    logic [2*RHalf-1:0] rll_reg;
    // Stage 6: numerator square.
    logic [NumW-1:0] num_reg;
    logic [DenW-1:0] den6_reg;
    logic [2:0] vt_reg;

    logic [LineW-1:0] sq_in [4];
    logic [ResW-1:0]  r_mag;

    function automatic logic [LineW-1:0] mag42(input logic signed [LineW-1:0] a);
        return a[LineW-1] ? LineW'(-a) : LineW'(a);
    endfunction

    function automatic logic [ResW-1:0] mag62(input logic signed [ResW-1:0] a);
        return a[ResW-1] ? ResW'(-a) : ResW'(a);
    endfunction

    // Squares are split into half-width products to keep each multiplier small.
    always_comb
    begin
        sq_in[0] = mag42(l_reg[0]);
        sq_in[1] = mag42(l_reg[1]);
        sq_in[2] = mag42(c_reg[0]);
        sq_in[3] = mag42(c_reg[1]);
        r_mag = mag62(r_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
            vt_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[1:0], in_valid};
            vt_reg <= {vt_reg[1:0], v_reg[2]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pl_reg[i][0] <= LineW'(cfg.f[i][0] * xu);
                pl_reg[i][1] <= LineW'(cfg.f[i][1] * xv);
                pl_reg[i][2] <= LineW'(cfg.f[i][2]) <<< 4;
            end
            for (int j = 0; j < 2; j++)
            begin
                pc_reg[j][0] <= LineW'(cfg.f[0][j] * yu);
                pc_reg[j][1] <= LineW'(cfg.f[1][j] * yv);
                pc_reg[j][2] <= LineW'(cfg.f[2][j]) <<< 4;
            end
            yu1_reg <= yu;
            yv1_reg <= yv;
            mode1_reg <= cfg.mode;

            for (int i = 0; i < 3; i++)
                l_reg[i] <= pl_reg[i][0] + pl_reg[i][1] + pl_reg[i][2];
            for (int j = 0; j < 2; j++)
                c_reg[j] <= pc_reg[j][0] + pc_reg[j][1] + pc_reg[j][2];
            yu2_reg <= yu1_reg;
            yv2_reg <= yv1_reg;
            mode2_reg <= mode1_reg;

            rp_reg[0] <= ResW'(yu2_reg * l_reg[0]);
            rp_reg[1] <= ResW'(yv2_reg * l_reg[1]);
            rp_reg[2] <= ResW'(l_reg[2]) <<< 4;
            for (int k = 0; k < 4; k++)
            begin
                phh_reg[k] <= (2*LHalf)'(sq_in[k][LineW-1:LHalf]) *
                              (2*LHalf)'(sq_in[k][LineW-1:LHalf]);
                phl_reg[k] <= (2*LHalf)'(sq_in[k][LineW-1:LHalf]) *
                              (2*LHalf)'(sq_in[k][LHalf-1:0]);
                pll_reg[k] <= (2*LHalf)'(sq_in[k][LHalf-1:0]) *
                              (2*LHalf)'(sq_in[k][LHalf-1:0]);
            end
            mode3_reg <= mode2_reg;

            r_reg <= rp_reg[0] + rp_reg[1] + rp_reg[2];
            for (int k = 0; k < 4; k++)
                sq_reg[k] <= (DenW'(phh_reg[k]) << (2*LHalf)) +
                             (DenW'(phl_reg[k]) << (LHalf+1)) + DenW'(pll_reg[k]);
            mode4_reg <= mode3_reg;

            den5_reg <= sq_reg[0] + sq_reg[1] +
                        (mode4_reg ? DenW'(0) : sq_reg[2] + sq_reg[3]);
            rhh_reg <= (2*RHalf)'(r_mag[ResW-1:RHalf]) * (2*RHalf)'(r_mag[ResW-1:RHalf]);
            rhl_reg <= (2*RHalf)'(r_mag[ResW-1:RHalf]) * (2*RHalf)'(r_mag[RHalf-1:0]);
            rll_reg <= (2*RHalf)'(r_mag[RHalf-1:0]) * (2*RHalf)'(r_mag[RHalf-1:0]);

            num_reg <= (NumW'(rhh_reg) << (2*RHalf)) + (NumW'(rhl_reg) << (RHalf+1)) +
                       NumW'(rll_reg);
            den6_reg <= den5_reg;
        end
    end

    assign out_valid = vt_reg[2];
    assign num = num_reg;
    assign den = den6_reg;
endmodule

/* rtl/esd_div.sv */
// Pipelined restoring divider with saturation and degenerate detection.
module esd_div
    import esd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [NumW-1:0] num,
    input  logic [DenW-1:0] den,
    output logic            out_valid,
    output logic [OutW-1:0] sqdist,
    output logic            degen
);
    // One quotient bit per stage, from bit QuoW-1 down to 0.
    logic            v_reg [QuoW+1];
    logic [NumW-1:0] n_reg [QuoW+1];
    logic [DenW-1:0] d_reg [QuoW+1];
    logic [QuoW-1:0] q_reg [QuoW+1];

    always_comb
    begin
        v_reg[0] = in_valid;
        n_reg[0] = num;
        d_reg[0] = den;
        q_reg[0] = '0;
    end

    for (genvar s = 0; s < QuoW; s++)
    begin : g_stage
        localparam int B = QuoW - 1 - s;
        logic [NumW+QuoW-1:0] sh;
        logic ge;
        assign sh = {{QuoW{1'b0}}, {(NumW-DenW){1'b0}}, d_reg[s]} << B;
        assign ge = {{QuoW{1'b0}}, n_reg[s]} >= sh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s+1] <= 1'b0;
            else if (en)
                v_reg[s+1] <= v_reg[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[s+1] <= ge ? NumW'({{QuoW{1'b0}}, n_reg[s]} - sh) : n_reg[s];
                d_reg[s+1] <= d_reg[s];
                q_reg[s+1] <= q_reg[s] | (ge ? (QuoW)'(1) << B : '0);
            end
        end
    end

    logic zero;
    assign zero = (d_reg[QuoW] == '0);
    assign out_valid = v_reg[QuoW];
    assign degen = zero;
    assign sqdist = (zero || q_reg[QuoW][QuoW-1:OutW] != '0) ? OUT_MAX
                    : q_reg[QuoW][OutW-1:0];
endmodule

/* rtl/epipolar_sampson_distance.sv */
// Top level of the epipolar Sampson distance scorer.
// Throughput: one item per cycle while the output is not stalled; 6 arithmetic stages then 41 divider stages.
// The whole pipeline advances together; a stalled output holds every stage.
// Reset (rst_n low, asynchronous) clears all valid bits and the F registers
// and distance mode to zero.
module epipolar_sampson_distance
    import esd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    esd_if.sink              pts,
    esd_if.source            res
);
    esd_cfg_t cfg;
    logic en;
    logic fv, dv;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
    logic [OutW-1:0] sqdist;
    logic degen;

    // The pipeline advances whenever the output is free or being taken.
    // The final stage is the output register, so a new item enters while
    // a result waits only if that result is consumed in the same cycle.
    assign en = res.ready || !res.valid;
    assign pts.ready = en;

    esd_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    esd_front u_front (
        .clk(clk), .rst_n(rst_n), .en(en), .cfg(cfg),
        .in_valid(pts.valid),
        .xu(pts.data[4*CoordW-1 -: CoordW]),
        .xv(pts.data[3*CoordW-1 -: CoordW]),
        .yu(pts.data[2*CoordW-1 -: CoordW]),
        .yv(pts.data[CoordW-1 -: CoordW]),
        .out_valid(fv), .num(num), .den(den)
    );

    esd_div u_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(fv), .num(num), .den(den),
        .out_valid(dv), .sqdist(sqdist), .degen(degen)
    );

    assign res.valid = dv;
    assign res.data = {sqdist, degen};

`ifndef SYNTHESIS
    // A degenerate result always carries the saturated distance.
    a_degen_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.data[0]) |-> (res.data[OutW:1] == OUT_MAX))
        else $error("degenerate result without saturated distance");
    // A stalled result must not change.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.ready) |=> (res.valid && $stable(res.data)))
        else $error("result changed while stalled");
    // Input is refused only when a result waits.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !pts.ready |-> (res.valid && !res.ready))
        else $error("input refused without back pressure");
`endif
endmodule
